// File: rtl/core/tte_pkg.sv
`timescale 1ns / 1ps
// tte_pkg: shared types, character codes and defaults for the text terminal parser
// no dependencies; imported by tte_front, tte_fifo, tte_back, the top level and the bench

package tte_pkg;

  // screen geometry defaults
  localparam int DEF_SCREEN_COLS = 80;
  localparam int DEF_SCREEN_ROWS = 60;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // widest row or column index the geometry range allows
  localparam int POS_W = 8;

  // item function codes
  localparam logic FUNC_PUT  = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  // character codes
  localparam logic [7:0] CH_ESC      = 8'h1b;
  localparam logic [7:0] CH_BS       = 8'h08;
  localparam logic [7:0] CH_CR       = 8'h0d;
  localparam logic [7:0] CH_LF       = 8'h0a;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_TILDE    = 8'h7e;
  localparam logic [7:0] CH_LBRACKET = 8'h5b;
  localparam logic [7:0] CH_K        = 8'h4b;
  localparam logic [7:0] CH_D        = 8'h44;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_NINE     = 8'h39;

  localparam logic [15:0] COUNT_MAX = 16'hffff;
  localparam int          DEC_BASE  = 10;

  typedef enum logic [1:0] {
    MODE_PRINT = 2'd0,
    MODE_ESC   = 2'd1,
    MODE_CMD   = 2'd2
  } mode_t;

  // screen operations the back end carries out
  typedef enum logic [2:0] {
    OP_NONE,
    OP_READ,
    OP_WRITE,
    OP_SCROLL,
    OP_ERASE
  } op_t;

  // one queued command with the result fields already settled by the front
  typedef struct packed {
    op_t              op;
    logic             wrap;
    logic [7:0]       chr;
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
    logic [6:0]       res_cursor;
    mode_t            res_mode;
  } cmd_t;

endpackage

// File: rtl/core/tte_in_if.sv
`timescale 1ns / 1ps
// tte_in_if: input channel of the text terminal parser, one character or read per beat
// no dependencies

interface tte_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] char_code;
  logic [5:0] read_row;
  logic [6:0] read_col;

  modport source (output valid, func, char_code, read_row, read_col, input ready);
  modport sink (input valid, func, char_code, read_row, read_col, output ready);
endinterface

// File: rtl/core/tte_out_if.sv
`timescale 1ns / 1ps
// tte_out_if: result channel of the text terminal parser, one result per beat
// no dependencies

interface tte_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_char;
  logic [6:0] cursor_col;
  logic [1:0] parser_mode;

  modport source (output valid, read_char, cursor_col, parser_mode, input ready);
  modport sink (input valid, read_char, cursor_col, parser_mode, output ready);
endinterface

// File: rtl/core/tte_ram.sv
`timescale 1ns / 1ps
// tte_ram: generic single-clock ram, one write and one registered read port
// no dependencies

module tte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4800
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/tte_front.sv
`timescale 1ns / 1ps
// tte_front: accepts beats, runs the escape parser, cursor and count, queues screen work
// depends on tte_pkg and tte_in_if

module tte_front import tte_pkg::*; #(
  parameter int SCREEN_COLS = DEF_SCREEN_COLS,
  parameter int SCREEN_ROWS = DEF_SCREEN_ROWS
) (
  input  logic       clk,
  input  logic       rst_n,
  tte_in_if.sink     in_ch,
  input  logic       init_done,
  input  logic       q_full,
  output logic       q_push,
  output cmd_t       q_cmd
);

  localparam int CW = $clog2(SCREEN_COLS);

  mode_t          mode_r, mode_nxt;
  logic [CW-1:0]  cursor_r, cursor_nxt;
  logic [15:0]    count_r, count_nxt;
  logic [19:0]    count_prod;

  assign in_ch.ready = init_done && !q_full;
  assign q_push      = in_ch.valid && in_ch.ready;

  // count * 10 + digit, saturated below
  assign count_prod = 20'(count_r) * 20'(DEC_BASE) + 20'(in_ch.char_code - CH_ZERO);

  always_comb begin
    mode_nxt   = mode_r;
    cursor_nxt = cursor_r;
    count_nxt  = count_r;
    q_cmd      = '0;
    q_cmd.op   = OP_NONE;
    q_cmd.wrap = 1'b0;
    q_cmd.chr  = in_ch.char_code;
    q_cmd.col  = POS_W'(cursor_r);
    q_cmd.row  = '0;
    if (in_ch.func == FUNC_READ) begin
      // a cell off the screen reads as zero without touching the ram
      if (int'(in_ch.read_row) < SCREEN_ROWS && int'(in_ch.read_col) < SCREEN_COLS) begin
        q_cmd.op  = OP_READ;
        q_cmd.row = POS_W'(in_ch.read_row);
        q_cmd.col = POS_W'(in_ch.read_col);
      end
    end else begin
      unique case (mode_r)
        MODE_PRINT: begin
          if (in_ch.char_code == CH_ESC) begin
            mode_nxt = MODE_ESC;
          end else if (in_ch.char_code == CH_BS) begin
            if (cursor_r != '0) begin
              cursor_nxt = cursor_r - CW'(1);
            end
          end else if (in_ch.char_code == CH_CR) begin
            cursor_nxt = '0;
          end else if (in_ch.char_code == CH_LF) begin
            q_cmd.op = OP_SCROLL;
          end else if (in_ch.char_code >= CH_SPACE && in_ch.char_code <= CH_TILDE) begin
            q_cmd.op = OP_WRITE;
            if (cursor_r == CW'(SCREEN_COLS - 1)) begin
              q_cmd.wrap = 1'b1;
              cursor_nxt = '0;
            end else begin
              cursor_nxt = cursor_r + CW'(1);
            end
          end
        end
        MODE_ESC: begin
          if (in_ch.char_code == CH_LBRACKET) begin
            mode_nxt  = MODE_CMD;
            count_nxt = '0;
          end else begin
            mode_nxt = MODE_PRINT;
          end
        end
        MODE_CMD: begin
          if (in_ch.char_code == CH_K) begin
            mode_nxt = MODE_PRINT;
            q_cmd.op = OP_ERASE;
          end else if (in_ch.char_code >= CH_ZERO && in_ch.char_code <= CH_NINE) begin
            count_nxt = (count_prod > 20'(COUNT_MAX)) ? COUNT_MAX : count_prod[15:0];
          end else if (in_ch.char_code == CH_D) begin
            mode_nxt = MODE_PRINT;
            if (count_r >= 16'(cursor_r)) begin
              cursor_nxt = '0;
            end else begin
              cursor_nxt = CW'(16'(cursor_r) - count_r);
            end
          end else begin
            mode_nxt = MODE_PRINT;
          end
        end
        default: begin
          mode_nxt = MODE_PRINT;
        end
      endcase
    end
    q_cmd.res_cursor = 7'(cursor_nxt);
    q_cmd.res_mode   = mode_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_PRINT;
      cursor_r <= '0;
      count_r  <= '0;
    end else if (q_push) begin
      mode_r   <= mode_nxt;
      cursor_r <= cursor_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// File: rtl/core/tte_fifo.sv
`timescale 1ns / 1ps
// tte_fifo: short command queue between parser front and screen back end
// depends on tte_pkg for the command type

module tte_fifo import tte_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t din,
  output logic full,
  input  logic pop,
  output cmd_t dout,
  output logic empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  cmd_t          slots [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [NW-1:0] fill_r;

  assign full  = (fill_r == NW'(DEPTH));
  assign empty = (fill_r == '0);
  assign dout  = slots[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        fill_r <= fill_r + NW'(1);
      end else if (pop && !push) begin
        fill_r <= fill_r - NW'(1);
      end
    end
  end

endmodule

// File: rtl/core/tte_back.sv
`timescale 1ns / 1ps
// tte_back: screen back end, circular row ram with scroll, row blanking, reads and results
// depends on tte_pkg, tte_out_if and tte_ram

module tte_back import tte_pkg::*; #(
  parameter int SCREEN_COLS = DEF_SCREEN_COLS,
  parameter int SCREEN_ROWS = DEF_SCREEN_ROWS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  cmd_t       q_cmd,
  input  logic       q_empty,
  output logic       q_pop,
  output logic       init_done,
  tte_out_if.source  out_ch
);

  localparam int CW    = $clog2(SCREEN_COLS);
  localparam int RW    = $clog2(SCREEN_ROWS);
  localparam int CELLS = SCREEN_ROWS * SCREEN_COLS;
  localparam int AW    = $clog2(CELLS);

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_RDWAIT,
    ST_BLANK,
    ST_DONE
  } state_t;

  state_t        state_r;
  logic [RW-1:0] top_r, bot_r;
  logic [AW-1:0] sweep_r;
  op_t           op_r;
  logic          wrap_r;
  logic [7:0]    chr_r;
  logic [CW-1:0] col_r, blank_col_r;
  logic [RW-1:0] prow_r;
  logic [6:0]    res_cursor_r;
  mode_t         res_mode_r;
  logic [7:0]    rd_char_r;

  logic          out_valid_r;
  logic [7:0]    out_char_r;
  logic [6:0]    out_cursor_r;
  logic [1:0]    out_mode_r;
  logic          out_load;

  logic [RW:0]   rot_sum;
  logic [RW-1:0] rot_row;
  logic [RW-1:0] top_inc;
  logic [CW-1:0] acc_col;
  logic [AW-1:0] cell_addr;
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_wdata;
  logic [7:0]    ram_rdata;

  // logical row to physical row through the top-of-screen pointer
  assign rot_sum = (RW+1)'(top_r) + (RW+1)'(q_cmd.row[RW-1:0]);
  assign rot_row = (rot_sum >= (RW+1)'(SCREEN_ROWS)) ?
                   RW'(rot_sum - (RW+1)'(SCREEN_ROWS)) : RW'(rot_sum);
  assign top_inc = (top_r == RW'(SCREEN_ROWS - 1)) ? '0 : top_r + RW'(1);

  assign acc_col   = (state_r == ST_BLANK) ? blank_col_r : col_r;
  assign cell_addr = AW'(prow_r) * AW'(SCREEN_COLS) + AW'(acc_col);

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = cell_addr;
    ram_wdata = CH_SPACE;
    case (state_r)
      ST_INIT: begin
        ram_we   = 1'b1;
        ram_addr = sweep_r;
      end
      ST_EXEC: begin
        if (op_r == OP_WRITE) begin
          ram_we    = 1'b1;
          ram_wdata = chr_r;
        end
      end
      ST_BLANK: begin
        ram_we = 1'b1;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  tte_ram #(
    .WIDTH (8),
    .DEPTH (CELLS)
  ) u_screen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_addr),
    .wdata (ram_wdata),
    .raddr (ram_addr),
    .rdata (ram_rdata)
  );

  assign q_pop     = (state_r == ST_IDLE) && !q_empty;
  assign init_done = (state_r != ST_INIT);

  // result register takes a new beat when empty or draining this cycle
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);

  assign out_ch.valid       = out_valid_r;
  assign out_ch.read_char   = out_char_r;
  assign out_ch.cursor_col  = out_cursor_r;
  assign out_ch.parser_mode = out_mode_r;

  // control state, payload and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      sweep_r     <= '0;
      top_r       <= '0;
      bot_r       <= RW'(SCREEN_ROWS - 1);
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready && !out_load) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_INIT: begin
          sweep_r <= sweep_r + AW'(1);
          if (sweep_r == AW'(CELLS - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (!q_empty) begin
            op_r         <= q_cmd.op;
            wrap_r       <= q_cmd.wrap;
            chr_r        <= q_cmd.chr;
            col_r        <= q_cmd.col[CW-1:0];
            prow_r       <= (q_cmd.op == OP_READ) ? rot_row : bot_r;
            res_cursor_r <= q_cmd.res_cursor;
            res_mode_r   <= q_cmd.res_mode;
            state_r      <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          rd_char_r <= '0;
          if (op_r == OP_READ) begin
            state_r <= ST_RDWAIT;
          end else if ((op_r == OP_WRITE && wrap_r) || op_r == OP_SCROLL) begin
            // old top row becomes the new bottom row
            prow_r      <= top_r;
            blank_col_r <= '0;
            top_r       <= top_inc;
            bot_r       <= top_r;
            state_r     <= ST_BLANK;
          end else if (op_r == OP_ERASE) begin
            blank_col_r <= col_r;
            state_r     <= ST_BLANK;
          end else begin
            state_r <= ST_DONE;
          end
        end
        ST_RDWAIT: begin
          rd_char_r <= ram_rdata;
          state_r   <= ST_DONE;
        end
        ST_BLANK: begin
          blank_col_r <= blank_col_r + CW'(1);
          if (blank_col_r == CW'(SCREEN_COLS - 1)) begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            out_char_r   <= rd_char_r;
            out_cursor_r <= res_cursor_r;
            out_mode_r   <= res_mode_r;
            out_valid_r  <= 1'b1;
            state_r      <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/core/text_terminal_escape_parser.sv
`timescale 1ns / 1ps
// text_terminal_escape_parser: character terminal with a small escape parser, top level
// depends on tte_pkg, tte_in_if, tte_out_if, tte_front, tte_fifo, tte_back, tte_ram
//
//  channel  | dir | handshake         | payload
//  ---------+-----+-------------------+---------------------------------------
//  in_ch    | in  | valid / ready     | func, char_code, read_row, read_col
//  out_ch   | out | valid / ready     | read_char, cursor_col, parser_mode
//
// after reset the back end sweeps every screen cell to space, one cell a cycle;
//   in_ch.ready stays low meanwhile
// a read passes through queue pop, execute, ram read and result register in the back
//   end, and a plain put skips the ram read; a scroll or erase adds blanking through
//   the single ram write port, one cell per cycle
// the front keeps taking beats while the queue has room, so the input side rides
//   over a stalled result; the back end waits only when the result register is full

module text_terminal_escape_parser import tte_pkg::*; #(
  parameter int SCREEN_COLS = DEF_SCREEN_COLS,
  parameter int SCREEN_ROWS = DEF_SCREEN_ROWS
) (
  input  logic      clk,
  input  logic      rst_n,
  tte_in_if.sink    in_ch,
  tte_out_if.source out_ch
);

  // front to queue
  logic q_push;
  cmd_t q_in;
  logic q_full;

  // queue to back
  logic q_pop;
  cmd_t q_out;
  logic q_empty;

  // back end finished its clearing sweep
  logic init_done;

  // parser, cursor and count; classifies each beat into a screen command
  tte_front #(
    .SCREEN_COLS (SCREEN_COLS),
    .SCREEN_ROWS (SCREEN_ROWS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .init_done (init_done),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_in)
  );

  // decouples parsing from the slow row-blanking work
  tte_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_in),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_out),
    .empty (q_empty)
  );

  // screen ram, scroll pointer, blanking and result register
  tte_back #(
    .SCREEN_COLS (SCREEN_COLS),
    .SCREEN_ROWS (SCREEN_ROWS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_cmd     (q_out),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .init_done (init_done),
    .out_ch    (out_ch)
  );

endmodule

// File: rtl/core/tte_checker.sv
`timescale 1ns / 1ps
// tte_checker: port-level checks for the text terminal parser, bound to the top level
// depends on text_terminal_escape_parser for the bind

module tte_checker #(
  parameter int SCREEN_COLS = 80
) (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_read_char,
  input logic [6:0] out_cursor_col,
  input logic [1:0] out_parser_mode
);

  // no result beat right after reset
  a_rst_no_result: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // clearing sweep holds off input after reset
  a_rst_no_ready: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("input ready right after reset");

  // cursor stays on the screen
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (SCREEN_COLS > 127 || int'(out_cursor_col) < SCREEN_COLS))
    else $error("cursor column off screen");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_read_char) && $stable(out_cursor_col)
                                && $stable(out_parser_mode))
    else $error("result payload changed while stalled");

endmodule

bind text_terminal_escape_parser tte_checker #(
  .SCREEN_COLS (SCREEN_COLS)
) u_tte_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_read_char   (out_ch.read_char),
  .out_cursor_col  (out_ch.cursor_col),
  .out_parser_mode (out_ch.parser_mode)
);

// File: sim/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for text_terminal_escape_parser, feeds characters and cell reads
// depends on tte_pkg, tte_in_if, tte_out_if and the block under test

module tb;
  import tte_pkg::*;

  localparam int COLS         = DEF_SCREEN_COLS;
  localparam int ROWS         = DEF_SCREEN_ROWS;
  localparam int RANDOM_ITEMS = 750;
  localparam int NUM_DIRECTED = 28;
  // a scroll or erase can blank up to a full row in the back end
  localparam int DRAIN_CYCLES = 2 * COLS + 50;
  // reset sweep plus the time each beat takes, with a wide margin
  localparam int CYCLE_LIMIT  = 500000;

  typedef struct packed {
    logic       func;
    logic [7:0] char_code;
    logic [5:0] read_row;
    logic [6:0] read_col;
  } term_item_t;

  typedef struct packed {
    logic [7:0] read_char;
    logic [6:0] cursor_col;
    mode_t      parser_mode;
  } term_result_t;

  typedef struct {
    term_item_t   item;
    bit           fixed;
    term_result_t want;
  } directed_row_t;

  typedef enum int {SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_CHOKE} sink_style_t;

  logic clk = 1'b0;
  logic rst_n;

  always #5 clk = ~clk;

  tte_in_if  in_ch ();
  tte_out_if out_ch ();

  text_terminal_escape_parser #(
    .SCREEN_COLS(COLS),
    .SCREEN_ROWS(ROWS)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // terminal state as the testbench sees it
  logic [7:0] screen [ROWS][COLS];
  int         cursor;
  mode_t      mode;
  int         count;

  term_result_t pending_results [$];
  int           items_sent   = 0;
  int           results_seen = 0;
  int           mismatches   = 0;
  int           burst_left   = 0;
  int           cycle_count  = 0;
  sink_style_t  sink_style   = SINK_OPEN;
  int           sink_left    = 0;

  // directed rows: fixed rows carry a typed-in result, the rest go through the predictor
  directed_row_t directed_rows [NUM_DIRECTED] = '{
    // fresh screen is all spaces
    '{'{FUNC_READ, 8'h00, 6'd0, 7'd0}, 1'b1, '{CH_SPACE, 7'd0, MODE_PRINT}},
    '{'{FUNC_READ, 8'h00, 6'd59, 7'd79}, 1'b1, '{CH_SPACE, 7'd0, MODE_PRINT}},
    // reads off the screen return zero
    '{'{FUNC_READ, 8'h00, 6'd63, 7'd127}, 1'b1, '{8'h00, 7'd0, MODE_PRINT}},
    '{'{FUNC_READ, 8'h00, 6'd60, 7'd0}, 1'b1, '{8'h00, 7'd0, MODE_PRINT}},
    '{'{FUNC_READ, 8'h00, 6'd0, 7'd80}, 1'b1, '{8'h00, 7'd0, MODE_PRINT}},
    // printable range edges
    '{'{FUNC_PUT, "A", 6'd0, 7'd0}, 1'b1, '{8'h00, 7'd1, MODE_PRINT}},
    '{'{FUNC_PUT, CH_TILDE, 6'd0, 7'd0}, 1'b1, '{8'h00, 7'd2, MODE_PRINT}},
    '{'{FUNC_PUT, CH_SPACE, 6'd0, 7'd0}, 1'b1, '{8'h00, 7'd3, MODE_PRINT}},
    // delete and high bytes are ignored
    '{'{FUNC_PUT, 8'h7f, 6'd0, 7'd0}, 1'b1, '{8'h00, 7'd3, MODE_PRINT}},
    '{'{FUNC_PUT, 8'hff, 6'd0, 7'd0}, 1'b1, '{8'h00, 7'd3, MODE_PRINT}},
    '{'{FUNC_PUT, CH_BS, 6'd0, 7'd0}, 1'b1, '{8'h00, 7'd2, MODE_PRINT}},
    '{'{FUNC_READ, 8'h00, 6'd59, 7'd1}, 1'b1, '{CH_TILDE, 7'd2, MODE_PRINT}},
    // escape followed by a stray byte drops back to printing
    '{'{FUNC_PUT, CH_ESC, 6'd0, 7'd0}, 1'b1, '{8'h00, 7'd2, MODE_ESC}},
    '{'{FUNC_PUT, "x", 6'd0, 7'd0}, 1'b1, '{8'h00, 7'd2, MODE_PRINT}},
    // count 65536 saturates, then move left past column zero
    '{'{FUNC_PUT, CH_ESC, 6'd0, 7'd0}, 1'b1, '{8'h00, 7'd2, MODE_ESC}},
    '{'{FUNC_PUT, CH_LBRACKET, 6'd0, 7'd0}, 1'b1, '{8'h00, 7'd2, MODE_CMD}},
    '{'{FUNC_PUT, "6", 6'd0, 7'd0}, 1'b1, '{8'h00, 7'd2, MODE_CMD}},
    '{'{FUNC_PUT, "5", 6'd0, 7'd0}, 1'b1, '{8'h00, 7'd2, MODE_CMD}},
    '{'{FUNC_PUT, "5", 6'd0, 7'd0}, 1'b1, '{8'h00, 7'd2, MODE_CMD}},
    '{'{FUNC_PUT, "3", 6'd0, 7'd0}, 1'b1, '{8'h00, 7'd2, MODE_CMD}},
    '{'{FUNC_PUT, "6", 6'd0, 7'd0}, 1'b1, '{8'h00, 7'd2, MODE_CMD}},
    '{'{FUNC_PUT, CH_D, 6'd0, 7'd0}, 1'b1, '{8'h00, 7'd0, MODE_PRINT}},
    // erase to end of row, then line feed
    '{'{FUNC_PUT, "Z", 6'd0, 7'd0}, 1'b0, '0},
    '{'{FUNC_PUT, CH_ESC, 6'd0, 7'd0}, 1'b0, '0},
    '{'{FUNC_PUT, CH_LBRACKET, 6'd0, 7'd0}, 1'b0, '0},
    '{'{FUNC_PUT, CH_K, 6'd0, 7'd0}, 1'b0, '0},
    '{'{FUNC_PUT, CH_LF, 6'd0, 7'd0}, 1'b0, '0},
    '{'{FUNC_READ, 8'h00, 6'd58, 7'd0}, 1'b0, '0}
  };

  function void scroll_screen();
    for (int r = 0; r < ROWS - 1; r++)
      for (int c = 0; c < COLS; c++)
        screen[r][c] = screen[r + 1][c];
    for (int c = 0; c < COLS; c++)
      screen[ROWS - 1][c] = CH_SPACE;
  endfunction

  // applies one beat to the terminal state and returns the result it should produce
  function automatic term_result_t terminal_step(input term_item_t it);
    term_result_t res;
    int           n;
    res = '0;
    if (it.func == FUNC_PUT) begin
      case (mode)
        MODE_PRINT: begin
          if (it.char_code == CH_ESC) begin
            mode = MODE_ESC;
          end else if (it.char_code == CH_BS) begin
            if (cursor > 0) cursor--;
          end else if (it.char_code == CH_CR) begin
            cursor = 0;
          end else if (it.char_code == CH_LF) begin
            scroll_screen();
          end else if (it.char_code >= CH_SPACE && it.char_code <= CH_TILDE) begin
            screen[ROWS - 1][cursor] = it.char_code;
            cursor++;
            // wrap past the last column
            if (cursor >= COLS) begin
              scroll_screen();
              cursor = 0;
            end
          end
        end
        MODE_ESC: begin
          if (it.char_code == CH_LBRACKET) begin
            mode  = MODE_CMD;
            count = 0;
          end else begin
            mode = MODE_PRINT;
          end
        end
        default: begin
          if (it.char_code == CH_K) begin
            mode = MODE_PRINT;
            for (int c = cursor; c < COLS; c++) screen[ROWS - 1][c] = CH_SPACE;
          end else if (it.char_code >= CH_ZERO && it.char_code <= CH_NINE) begin
            n     = count * DEC_BASE + int'(it.char_code - CH_ZERO);
            count = (n > int'(COUNT_MAX)) ? int'(COUNT_MAX) : n;
          end else if (it.char_code == CH_D) begin
            mode   = MODE_PRINT;
            cursor = (count >= cursor) ? 0 : cursor - count;
          end else begin
            mode = MODE_PRINT;
          end
        end
      endcase
    end else if (it.read_row < ROWS && it.read_col < COLS) begin
      res.read_char = screen[it.read_row][it.read_col];
    end
    res.cursor_col  = 7'(cursor);
    res.parser_mode = mode;
    return res;
  endfunction

  // drives one beat at a falling edge, in bursts separated by random gaps
  task automatic send_item(input term_item_t it, input bit fixed, input term_result_t want);
    int           gap;
    int           roll;
    term_result_t predicted;
    if (burst_left == 0) begin
      roll = $urandom_range(0, 19);
      if (roll == 0)     gap = $urandom_range(20, 60);
      else if (roll < 4) gap = $urandom_range(4, 12);
      else if (roll < 10) gap = $urandom_range(1, 3);
      else               gap = 0;
      // now and then a long burst with no idling at all
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200) : $urandom_range(1, 24);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_ch.valid     <= 1'b1;
    in_ch.func      <= it.func;
    in_ch.char_code <= it.char_code;
    in_ch.read_row  <= it.read_row;
    in_ch.read_col  <= it.read_col;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    // beat taken at this edge
    predicted = terminal_step(it);
    pending_results.push_back(fixed ? want : predicted);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic put_char(input logic [7:0] c);
    term_item_t it;
    it           = '0;
    it.func      = FUNC_PUT;
    it.char_code = c;
    send_item(it, 1'b0, '0);
  endtask

  task automatic read_cell(input int r, input int c);
    term_item_t it;
    it          = '0;
    it.func     = FUNC_READ;
    it.read_row = 6'(r);
    it.read_col = 7'(c);
    send_item(it, 1'b0, '0);
  endtask

  task automatic report_mismatch(input string what);
    $display("[%0t] result %0d: %s", $time, results_seen, what);
    mismatches++;
  endtask

  // result side stalls in phases of its own
  always @(negedge clk) begin
    if (sink_left == 0) begin
      sink_style = sink_style_t'($urandom_range(0, 3));
      sink_left  = $urandom_range(16, 160);
    end
    sink_left--;
    case (sink_style)
      SINK_OPEN:   out_ch.ready <= 1'b1;
      SINK_COIN:   out_ch.ready <= 1'($urandom_range(0, 1));
      SINK_SPARSE: out_ch.ready <= (sink_left % 4 == 0);
      default:     out_ch.ready <= ($urandom_range(0, 15) == 0);
    endcase
  end

  // compare each result beat with the oldest pending result
  always @(posedge clk) begin
    term_result_t want;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result beat with nothing pending");
      end else begin
        want = pending_results.pop_front();
        if (out_ch.read_char !== want.read_char)
          report_mismatch($sformatf("read_char %h, wanted %h", out_ch.read_char, want.read_char));
        if (out_ch.cursor_col !== want.cursor_col)
          report_mismatch($sformatf("cursor_col %0d, wanted %0d",
                                    out_ch.cursor_col, want.cursor_col));
        if (out_ch.parser_mode !== want.parser_mode)
          report_mismatch($sformatf("parser_mode %0d, wanted %0d",
                                    out_ch.parser_mode, want.parser_mode));
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout with %0d results pending", pending_results.size());
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int roll;
    int len;
    int digits;
    in_ch.valid     = 1'b0;
    in_ch.func      = FUNC_PUT;
    in_ch.char_code = 8'h00;
    in_ch.read_row  = 6'd0;
    in_ch.read_col  = 7'd0;
    out_ch.ready    = 1'b0;
    rst_n           = 1'b0;
    for (int r = 0; r < ROWS; r++)
      for (int c = 0; c < COLS; c++)
        screen[r][c] = CH_SPACE;
    cursor = 0;
    mode   = MODE_PRINT;
    count  = 0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_item(directed_rows[i].item, directed_rows[i].fixed, directed_rows[i].want);

    // random part: mostly text runs and well-formed commands, some noise
    while (items_sent < NUM_DIRECTED + RANDOM_ITEMS) begin
      roll = $urandom_range(0, 19);
      if (roll < 7) begin
        // text run, long enough to wrap now and then
        len = $urandom_range(1, 40);
        repeat (len) begin
          case ($urandom_range(0, 31))
            0:       put_char(CH_CR);
            1:       put_char(CH_BS);
            default: put_char(8'($urandom_range(CH_SPACE, CH_TILDE)));
          endcase
        end
      end else if (roll < 10) begin
        case ($urandom_range(0, 2))
          0:       put_char(CH_BS);
          1:       put_char(CH_CR);
          default: put_char(CH_LF);
        endcase
      end else if (roll < 14) begin
        // bracket command with a short count, sometimes long enough to saturate
        put_char(CH_ESC);
        put_char(CH_LBRACKET);
        digits = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 6) : $urandom_range(0, 2);
        repeat (digits) put_char(CH_ZERO + 8'($urandom_range(0, 9)));
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: put_char(CH_D);
          5, 6, 7:       put_char(CH_K);
          default:       put_char(8'($urandom_range(0, 255)));
        endcase
      end else if (roll == 14) begin
        // broken sequence: escape or command cut by an arbitrary byte
        put_char(CH_ESC);
        if ($urandom_range(0, 1)) begin
          put_char(CH_LBRACKET);
          put_char(CH_ZERO + 8'($urandom_range(0, 9)));
        end
        put_char(8'($urandom_range(0, 255)));
      end else if (roll < 18) begin
        // reads lean on the rows that text has reached
        case ($urandom_range(0, 19))
          0, 1, 2:       read_cell($urandom_range(0, 63), $urandom_range(0, 127));
          3, 4, 5, 6, 7: read_cell($urandom_range(0, ROWS - 1), $urandom_range(0, COLS - 1));
          default:       read_cell($urandom_range(ROWS - 4, ROWS - 1), $urandom_range(0, COLS - 1));
        endcase
      end else begin
        put_char(8'($urandom_range(0, 255)));
      end
    end

    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // let any stray beat show up before the verdict
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
